FILE: rtl/ifp_pkg.sv
// Shared constants, widths and the acceleration scaling function for the IMU frame parser.
package ifp_pkg;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 5;
	localparam int RAW_W   = 16;
	localparam int ACCEL_W = 20;
	localparam int SCALE_W = 15;
	localparam int PROD_W  = RAW_W + SCALE_W;
	localparam int FRAC_W  = 10;
	localparam int AXES    = 3;

	localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
	localparam logic [POS_W-1:0]  ACC_FIRST = 5'd7;
	localparam logic [POS_W-1:0]  ACC_LAST  = 5'd12;

	// 10283/1024 approximates 9.80665 * 1024 / 1000
	localparam logic signed [SCALE_W-1:0] SCALE_NUM = 15'sd10283;

	// floor(-32768 * 10283 / 1024) and floor(32767 * 10283 / 1024)
	localparam int ACCEL_MIN = -329056;
	localparam int ACCEL_MAX = 329045;

	typedef logic [RAW_W-1:0]          raw_t;
	typedef logic signed [ACCEL_W-1:0] accel_t;

	// floor(raw * 10283 / 1024): arithmetic shift of the product rounds toward minus infinity
	function automatic accel_t scale_accel(input raw_t raw);
		logic signed [PROD_W-1:0] prod;
		prod = PROD_W'($signed(raw) * SCALE_NUM);
		return prod[FRAC_W+ACCEL_W-1:FRAC_W];
	endfunction

endpackage

FILE: rtl/imu_frame_parser_with_checksum.sv
// Top level of the IMU serial frame parser with mod-256 checksum and acceleration scaling.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------------
//  rx      | rx_valid/rx_ready  | rx_byte
//  res     | res_valid/res_ready| frame_status, sum_received, sum_computed, accel_x/y/z
//
// One byte per cycle sustained: a received byte is registered in the input register,
// where the parser state advances, and a finished frame lands in the result register.
// A result is registered as its checksum byte leaves the input register, 19 or more
// bytes per frame. While a result waits, bytes that complete no frame keep flowing; only a
// checksum byte stalls in the input register until the result register frees up.
// arst_n clears the handshake flags and the parser back to hunting for a header.
module imu_frame_parser_with_checksum
	import ifp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rx_valid,
	output logic                      rx_ready,
	input  logic [BYTE_W-1:0]         rx_byte,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic                      frame_status,
	output logic [BYTE_W-1:0]         sum_received,
	output logic [BYTE_W-1:0]         sum_computed,
	output logic signed [ACCEL_W-1:0] accel_x,
	output logic signed [ACCEL_W-1:0] accel_y,
	output logic signed [ACCEL_W-1:0] accel_z
);

	typedef enum logic [1:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_BODY
	} phase_t;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	phase_t            phase_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] held_q;
	raw_t              raw_q [AXES];

	// result register
	logic              res_valid_q;
	logic              status_q;
	logic [BYTE_W-1:0] sum_rx_q;
	logic [BYTE_W-1:0] sum_calc_q;
	accel_t            accel_q [AXES];

	logic             out_free;
	logic             frame_end;
	logic             s1_fire;
	logic             in_accel;
	logic [POS_W-1:0] rel;

	// a checksum byte arrives in the body once all sixteen payload bytes are in
	assign frame_end = (phase_q == PH_BODY) && pos_q[POS_W-1];
	assign out_free  = !res_valid_q || res_ready;
	// hold the input register only when it carries a checksum byte and the result is stuck
	assign s1_fire   = valid_s1 && (!frame_end || out_free);
	assign rx_ready  = !valid_s1 || s1_fire;

	assign rel      = pos_q - ACC_FIRST;
	assign in_accel = (pos_q >= ACC_FIRST) && (pos_q <= ACC_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_HUNT1;
			pos_q       <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx_ready) begin
				valid_s1 <= rx_valid;
				if (rx_valid) begin
					byte_s1 <= rx_byte;
				end
			end

			// drop the result once taken, unless a new frame lands in the same cycle
			if (res_ready && !(s1_fire && frame_end)) begin
				res_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				case (phase_q)
					PH_HUNT1: begin
						phase_q <= (byte_s1 == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
					end
					PH_HUNT2: begin
						if (byte_s1 == HDR_BYTE) begin
							phase_q <= PH_BODY;
							pos_q   <= '0;
							sum_q   <= '0;
						end else begin
							phase_q <= PH_HUNT1;
						end
					end
					PH_BODY: begin
						if (frame_end) begin
							res_valid_q <= 1'b1;
							status_q    <= (byte_s1 != sum_q);
							sum_rx_q    <= byte_s1;
							sum_calc_q  <= sum_q;
							for (int i = 0; i < AXES; i++) begin
								accel_q[i] <= scale_accel(raw_q[i]);
							end
							phase_q <= PH_HUNT1;
							pos_q   <= '0;
							sum_q   <= '0;
						end else begin
							sum_q <= sum_q + byte_s1;
							pos_q <= pos_q + POS_W'(1);
							// low byte first, then the high byte completes the axis
							if (in_accel) begin
								if (!rel[0]) begin
									held_q <= byte_s1;
								end else begin
									raw_q[rel[2:1]] <= {byte_s1, held_q};
								end
							end
						end
					end
					default: begin
						// unused phase code hunts for the first header byte
						phase_q <= (byte_s1 == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
					end
				endcase
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_status = status_q;
	assign sum_received = sum_rx_q;
	assign sum_computed = sum_calc_q;
	assign accel_x      = accel_q[0];
	assign accel_y      = accel_q[1];
	assign accel_z      = accel_q[2];

endmodule

FILE: rtl/ifp_checker.sv
// Port-level checker for the IMU frame parser, bound to the top level.
module ifp_checker
	import ifp_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rx_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic                      frame_status,
	input logic [BYTE_W-1:0]         sum_received,
	input logic [BYTE_W-1:0]         sum_computed,
	input logic signed [ACCEL_W-1:0] accel_x,
	input logic signed [ACCEL_W-1:0] accel_y,
	input logic signed [ACCEL_W-1:0] accel_z
);

	// a stalled result transaction holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(sum_received)
			&& $stable(sum_computed) && $stable(frame_status)
			&& $stable(accel_x) && $stable(accel_y) && $stable(accel_z))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> frame_status == (sum_received != sum_computed))
		else $error("status disagrees with checksums");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($signed(accel_x) >= ACCEL_MIN) && ($signed(accel_x) <= ACCEL_MAX)
			&& ($signed(accel_y) >= ACCEL_MIN) && ($signed(accel_y) <= ACCEL_MAX)
			&& ($signed(accel_z) >= ACCEL_MIN) && ($signed(accel_z) <= ACCEL_MAX))
		else $error("acceleration out of scaled range");

	// with an empty result register the input must be ready for a byte
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input stalled with empty result register");

endmodule

bind imu_frame_parser_with_checksum ifp_checker u_ifp_checker (.*);
